@@ hdl/dmac_pkg.sv @@
`default_nettype none

package dmac_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int WIN_W      = 6;
    localparam int PCT_W      = 7;
    localparam int TMO_W      = 16;
    localparam int VAL_W      = 16;
    localparam int MAG_W      = 17;
    localparam int SUM_W      = 22;
    localparam int CFG_AW     = 2;
    localparam int CFG_DW     = 16;

    localparam int DIV_NW     = SUM_W + PCT_W;
    localparam int DIV_DW     = SUM_W + 1;
    localparam int DIV_CW     = $clog2(DIV_NW);

    typedef enum logic [1:0] {
        OP_X     = 2'd0,
        OP_Y     = 2'd1,
        OP_OTHER = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    localparam logic [1:0] LOCK_NONE = 2'd0;
    localparam logic [1:0] LOCK_X    = 2'd1;
    localparam logic [1:0] LOCK_Y    = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_WINDOW     = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_HYSTERESIS = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_TIMEOUT    = 2'd3;

    localparam logic [WIN_W-1:0] WINDOW_RST     = 6'd24;
    localparam logic [PCT_W-1:0] THRESHOLD_RST  = 7'd35;
    localparam logic [PCT_W-1:0] HYSTERESIS_RST = 7'd5;
    localparam logic [TMO_W-1:0] TIMEOUT_RST    = 16'd100;

    function automatic logic [CNT_W-1:0] used_window(input logic [WIN_W-1:0] wl);
        logic [CNT_W-1:0] w;
        if (wl < WIN_W'(2)) begin
            w = CNT_W'(2);
        end else if (wl > WIN_W'(MAX_WINDOW)) begin
            w = CNT_W'(MAX_WINDOW);
        end else begin
            w = CNT_W'(wl);
        end
        return w;
    endfunction

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [VAL_W-1:0] v);
        logic [MAG_W-1:0] e;
        e = {v[VAL_W-1], v};
        return v[VAL_W-1] ? (MAG_W'(0) - e) : e;
    endfunction

endpackage

`default_nettype wire

@@ hdl/dmac_div.sv @@
`default_nettype none

module dmac_div
    import dmac_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_NW-1:0] dividend,
    input  wire logic [DIV_DW-1:0] divisor,
    output logic                   done,
    output logic      [DIV_NW-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] count_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dsr_reg;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              fits;
    logic [DIV_DW-1:0] rem_next;

    assign trial    = {rem_reg, quo_reg[DIV_NW-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign rem_next = fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_CW'(DIV_NW - 1);
            end else if (busy_reg) begin
                count_reg <= count_reg - DIV_CW'(1);
                if (count_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ hdl/dominant_axis_motion_clamper.sv @@
`default_nettype none

// Channel   Handshake          Beat payload
// s_        s_valid/s_ready    s_opcode, s_motion_value, s_sync_in
// m_        m_valid/m_ready    m_event_kind, m_value_out, m_sync_out, m_lock_state
// cfg_      cfg_wr_en          cfg_addr, cfg_wr_data
//
// One beat at a time. A tick is handled when accepted and gives no output beat;
// an other event goes straight to the result step. A motion beat walks both
// rings over W entries (W = used window), then the bit-serial dividers: none if
// a ring holds under W/2 entries, one if both averages are zero, else two passes.
// Reset is synchronous; history valid bits clear at once. A held result stalls
// only the last step; the next beat is taken once the current one is finished.

module dominant_axis_motion_clamper
    import dmac_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_opcode,
    input  wire logic signed [VAL_W-1:0] s_motion_value,
    input  wire logic                    s_sync_in,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_event_kind,
    output logic signed [VAL_W-1:0]      m_value_out,
    output logic                         m_sync_out,
    output logic [1:0]                   m_lock_state,

    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_AW-1:0]       cfg_addr,
    input  wire logic [CFG_DW-1:0]       cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_LAST,
        ST_CHECK,
        ST_DIV1,
        ST_DIV2,
        ST_DONE
    } state_t;

    state_t              state_reg;

    logic [WIN_W-1:0]    window_reg;
    logic [PCT_W-1:0]    thr_reg;
    logic [PCT_W-1:0]    hyst_reg;
    logic [TMO_W-1:0]    timeout_reg;

    logic [MAG_W-1:0]    x_ring [MAX_WINDOW];
    logic [MAG_W-1:0]    y_ring [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] x_vld_reg;
    logic [MAX_WINDOW-1:0] y_vld_reg;
    logic [MAG_W-1:0]    x_rd_reg;
    logic [MAG_W-1:0]    y_rd_reg;
    logic                x_rd_ok_reg;
    logic                y_rd_ok_reg;
    logic                rd_live_reg;

    logic [SLOT_W-1:0]   x_slot_reg;
    logic [SLOT_W-1:0]   y_slot_reg;
    logic [CNT_W-1:0]    x_fill_reg;
    logic [CNT_W-1:0]    y_fill_reg;
    logic                lock_x_reg;
    logic                lock_y_reg;
    logic [TMO_W-1:0]    idle_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [SUM_W-1:0]    x_sum_reg;
    logic [SUM_W-1:0]    y_sum_reg;

    op_t                 op_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                sync_reg;
    logic                suppress_reg;

    logic                m_valid_reg;
    logic [1:0]          m_kind_reg;
    logic signed [VAL_W-1:0] m_value_reg;
    logic                m_sync_reg;
    logic [1:0]          m_lock_reg;

    logic [CNT_W-1:0]    w;
    logic [CNT_W-1:0]    half;
    logic                accept;
    op_t                 s_op;
    logic [MAG_W-1:0]    mag;
    logic [SLOT_W-1:0]   x_slot_eff;
    logic [SLOT_W-1:0]   y_slot_eff;
    logic [CNT_W-1:0]    x_slot_inc;
    logic [CNT_W-1:0]    y_slot_inc;
    logic [SLOT_W-1:0]   x_slot_next;
    logic [SLOT_W-1:0]   y_slot_next;
    logic [CNT_W-1:0]    x_fill_inc;
    logic [CNT_W-1:0]    y_fill_inc;
    logic [CNT_W-1:0]    x_fill_next;
    logic [CNT_W-1:0]    y_fill_next;
    logic [TMO_W-1:0]    idle_next;
    logic [MAG_W-1:0]    x_entry;
    logic [MAG_W-1:0]    y_entry;
    logic                fills_ok;

    logic                div_start;
    logic [DIV_NW-1:0]   dx_dividend;
    logic [DIV_NW-1:0]   dy_dividend;
    logic [DIV_DW-1:0]   dx_divisor;
    logic [DIV_DW-1:0]   dy_divisor;
    logic                dx_done;
    logic                dy_done;
    logic [DIV_NW-1:0]   qx;
    logic [DIV_NW-1:0]   qy;
    logic [SUM_W-1:0]    xa;
    logic [SUM_W-1:0]    ya;
    logic [DIV_DW-1:0]   total;
    logic [DIV_NW-1:0]   x_scaled;
    logic [DIV_NW-1:0]   y_scaled;
    logic [PCT_W-1:0]    xp;
    logic [PCT_W-1:0]    yp;
    logic                hyst_over;
    logic [PCT_W-1:0]    rel_level;
    logic                lock_x_next;
    logic                lock_y_next;

    assign s_op    = op_t'(s_opcode);
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign w    = used_window(window_reg);
    assign half = w >> 1;
    assign mag  = abs_mag(s_motion_value);

    assign x_slot_eff  = ({1'b0, x_slot_reg} >= w) ? '0 : x_slot_reg;
    assign y_slot_eff  = ({1'b0, y_slot_reg} >= w) ? '0 : y_slot_reg;
    assign x_slot_inc  = {1'b0, x_slot_eff} + CNT_W'(1);
    assign y_slot_inc  = {1'b0, y_slot_eff} + CNT_W'(1);
    assign x_slot_next = (x_slot_inc == w) ? '0 : x_slot_inc[SLOT_W-1:0];
    assign y_slot_next = (y_slot_inc == w) ? '0 : y_slot_inc[SLOT_W-1:0];
    assign x_fill_inc  = x_fill_reg + CNT_W'(1);
    assign y_fill_inc  = y_fill_reg + CNT_W'(1);
    assign x_fill_next = (x_fill_inc > w) ? w : x_fill_inc;
    assign y_fill_next = (y_fill_inc > w) ? w : y_fill_inc;
    assign idle_next   = (idle_reg == '1) ? idle_reg : idle_reg + TMO_W'(1);

    assign x_entry  = x_rd_ok_reg ? x_rd_reg : '0;
    assign y_entry  = y_rd_ok_reg ? y_rd_reg : '0;
    assign fills_ok = (x_fill_reg >= half) && (y_fill_reg >= half);

    assign xa       = qx[SUM_W-1:0];
    assign ya       = qy[SUM_W-1:0];
    assign total    = {1'b0, xa} + {1'b0, ya};
    assign x_scaled = DIV_NW'({xa, 6'b0}) + DIV_NW'({xa, 5'b0}) + DIV_NW'({xa, 2'b0});
    assign y_scaled = DIV_NW'({ya, 6'b0}) + DIV_NW'({ya, 5'b0}) + DIV_NW'({ya, 2'b0});
    assign xp       = qx[PCT_W-1:0];
    assign yp       = qy[PCT_W-1:0];

    assign div_start = ((state_reg == ST_CHECK) && fills_ok)
                    || ((state_reg == ST_DIV1) && dx_done && (total != '0));
    assign dx_dividend = (state_reg == ST_CHECK) ? DIV_NW'(x_sum_reg) : x_scaled;
    assign dy_dividend = (state_reg == ST_CHECK) ? DIV_NW'(y_sum_reg) : y_scaled;
    assign dx_divisor  = (state_reg == ST_CHECK) ? DIV_DW'(x_fill_reg) : total;
    assign dy_divisor  = (state_reg == ST_CHECK) ? DIV_DW'(y_fill_reg) : total;

    dmac_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dx_dividend),
        .divisor  (dx_divisor),
        .done     (dx_done),
        .quotient (qx)
    );

    dmac_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dy_dividend),
        .divisor  (dy_divisor),
        .done     (dy_done),
        .quotient (qy)
    );

    assign hyst_over = hyst_reg > thr_reg;
    assign rel_level = thr_reg - hyst_reg;

    always_comb begin
        lock_x_next = lock_x_reg;
        lock_y_next = lock_y_reg;
        if (!lock_x_reg && !lock_y_reg) begin
            if (xp >= thr_reg) begin
                lock_x_next = 1'b1;
            end else if (yp >= thr_reg) begin
                lock_y_next = 1'b1;
            end
        end else if (lock_x_reg) begin
            if (hyst_over || (xp < rel_level)) begin
                lock_x_next = 1'b0;
            end
        end else begin
            if (hyst_over || (yp < rel_level)) begin
                lock_y_next = 1'b0;
            end
        end
    end

    // history rings: one write at the slot, one registered read at the walk index
    always_ff @(posedge aclk) begin
        if (accept && (s_op == OP_X)) begin
            x_ring[x_slot_eff] <= mag;
        end
        if (accept && (s_op == OP_Y)) begin
            y_ring[y_slot_eff] <= mag;
        end
        x_rd_reg    <= x_ring[idx_reg[SLOT_W-1:0]];
        y_rd_reg    <= y_ring[idx_reg[SLOT_W-1:0]];
        x_rd_ok_reg <= x_vld_reg[idx_reg[SLOT_W-1:0]];
        y_rd_ok_reg <= y_vld_reg[idx_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= WINDOW_RST;
            thr_reg     <= THRESHOLD_RST;
            hyst_reg    <= HYSTERESIS_RST;
            timeout_reg <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_WINDOW:     window_reg  <= cfg_wr_data[WIN_W-1:0];
                CFG_THRESHOLD:  thr_reg     <= cfg_wr_data[PCT_W-1:0];
                CFG_HYSTERESIS: hyst_reg    <= cfg_wr_data[PCT_W-1:0];
                CFG_TIMEOUT:    timeout_reg <= cfg_wr_data[TMO_W-1:0];
                default:        window_reg  <= window_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            x_vld_reg    <= '0;
            y_vld_reg    <= '0;
            x_slot_reg   <= '0;
            y_slot_reg   <= '0;
            x_fill_reg   <= '0;
            y_fill_reg   <= '0;
            lock_x_reg   <= 1'b0;
            lock_y_reg   <= 1'b0;
            idle_reg     <= '0;
            idx_reg      <= '0;
            rd_live_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            suppress_reg <= 1'b0;
        end else begin
            rd_live_reg <= (state_reg == ST_SUM);
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg       <= s_op;
                        value_reg    <= s_motion_value;
                        sync_reg     <= s_sync_in;
                        suppress_reg <= 1'b0;
                        idx_reg      <= '0;
                        x_sum_reg    <= '0;
                        y_sum_reg    <= '0;
                        if (s_op == OP_TICK) begin
                            idle_reg <= idle_next;
                            if (idle_next >= timeout_reg) begin
                                x_vld_reg  <= '0;
                                y_vld_reg  <= '0;
                                x_slot_reg <= '0;
                                y_slot_reg <= '0;
                                x_fill_reg <= '0;
                                y_fill_reg <= '0;
                                lock_x_reg <= 1'b0;
                                lock_y_reg <= 1'b0;
                            end
                        end else begin
                            idle_reg <= '0;
                            if (s_op == OP_X) begin
                                x_vld_reg[x_slot_eff] <= 1'b1;
                                x_slot_reg <= x_slot_next;
                                x_fill_reg <= x_fill_next;
                                state_reg  <= ST_SUM;
                            end else if (s_op == OP_Y) begin
                                y_vld_reg[y_slot_eff] <= 1'b1;
                                y_slot_reg <= y_slot_next;
                                y_fill_reg <= y_fill_next;
                                state_reg  <= ST_SUM;
                            end else begin
                                state_reg <= ST_DONE;
                            end
                        end
                    end
                end
                ST_SUM: begin
                    if (rd_live_reg) begin
                        x_sum_reg <= x_sum_reg + SUM_W'(x_entry);
                        y_sum_reg <= y_sum_reg + SUM_W'(y_entry);
                    end
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (idx_reg == w - CNT_W'(1)) begin
                        state_reg <= ST_SUM_LAST;
                    end
                end
                ST_SUM_LAST: begin
                    x_sum_reg <= x_sum_reg + SUM_W'(x_entry);
                    y_sum_reg <= y_sum_reg + SUM_W'(y_entry);
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    state_reg <= fills_ok ? ST_DIV1 : ST_DONE;
                end
                ST_DIV1: begin
                    if (dx_done && dy_done) begin
                        state_reg <= (total != '0) ? ST_DIV2 : ST_DONE;
                    end
                end
                ST_DIV2: begin
                    if (dx_done && dy_done) begin
                        lock_x_reg   <= lock_x_next;
                        lock_y_reg   <= lock_y_next;
                        suppress_reg <= (lock_x_next && (op_reg == OP_Y))
                                     || (lock_y_next && (op_reg == OP_X));
                        state_reg    <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= op_reg;
                        m_value_reg <= suppress_reg ? '0 : value_reg;
                        m_sync_reg  <= suppress_reg ? 1'b0 : sync_reg;
                        m_lock_reg  <= lock_x_reg ? LOCK_X : (lock_y_reg ? LOCK_Y : LOCK_NONE);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = m_kind_reg;
    assign m_value_out  = m_value_reg;
    assign m_sync_out   = m_sync_reg;
    assign m_lock_state = m_lock_reg;

endmodule

`default_nettype wire

@@ sim/tb_dominant_axis_motion_clamper.sv @@
`default_nettype none

module tb_dominant_axis_motion_clamper;
    import dmac_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_PHASES = 6;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] value;
        logic             sync;
        logic [1:0]       lock;
    } clamp_beat_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [1:0]              s_opcode;
    logic signed [VAL_W-1:0] s_motion_value;
    logic                    s_sync_in;
    logic                    m_valid;
    logic                    m_ready;
    logic [1:0]              m_event_kind;
    logic signed [VAL_W-1:0] m_value_out;
    logic                    m_sync_out;
    logic [1:0]              m_lock_state;
    logic                    cfg_wr_en;
    logic [CFG_AW-1:0]       cfg_addr;
    logic [CFG_DW-1:0]       cfg_wr_data;

    dominant_axis_motion_clamper dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_motion_value (s_motion_value),
        .s_sync_in      (s_sync_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_value_out    (m_value_out),
        .m_sync_out     (m_sync_out),
        .m_lock_state   (m_lock_state),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data)
    );

    // clamper state mirror
    logic [MAG_W-1:0] hist [2][MAX_WINDOW];
    int unsigned      slot [2];
    int unsigned      fill [2];
    bit               lock_x;
    bit               lock_y;
    int unsigned      idle_ticks;
    logic [WIN_W-1:0] reg_window;
    logic [PCT_W-1:0] reg_threshold;
    logic [PCT_W-1:0] reg_hysteresis;
    logic [TMO_W-1:0] reg_timeout;

    clamp_beat_t predicted_beats [$];
    int          fail_count;
    int          cycle_count;
    bit          quiet;
    int          stall_len;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dominant_axis_motion_clamper test failed");
            $finish;
        end
    end

    function automatic void wipe_mirror();
        for (int a = 0; a < 2; a++) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                hist[a][i] = '0;
            end
            slot[a] = 0;
            fill[a] = 0;
        end
        lock_x = 1'b0;
        lock_y = 1'b0;
    endfunction

    function automatic bit lock_released(input int unsigned pct);
        if (reg_hysteresis > reg_threshold) begin
            return 1'b1;
        end
        return pct < int'(reg_threshold) - int'(reg_hysteresis);
    endfunction

    task automatic predict_clamp(input op_t op, input logic [VAL_W-1:0] raw, input logic sync);
        int unsigned w;
        int unsigned mag;
        int unsigned s;
        int unsigned sum [2];
        int unsigned avg_x;
        int unsigned avg_y;
        int unsigned total;
        int unsigned pct_x;
        int unsigned pct_y;
        int          a;
        bit          hide;
        clamp_beat_t r;
        hide = 1'b0;
        if (op == OP_TICK) begin
            if (idle_ticks < 65535) begin
                idle_ticks++;
            end
            if (idle_ticks >= reg_timeout) begin
                wipe_mirror();
            end
            return;
        end
        idle_ticks = 0;
        if (op == OP_X || op == OP_Y) begin
            if (reg_window < 2) begin
                w = 2;
            end else if (reg_window > MAX_WINDOW) begin
                w = MAX_WINDOW;
            end else begin
                w = reg_window;
            end
            mag = raw[VAL_W-1] ? (32'h10000 - raw) : raw;
            a = (op == OP_X) ? 0 : 1;
            s = (slot[a] >= w) ? 0 : slot[a];
            hist[a][s] = MAG_W'(mag);
            slot[a] = (s + 1) % w;
            fill[a] = (fill[a] + 1 > w) ? w : fill[a] + 1;
            sum[0] = 0;
            sum[1] = 0;
            for (int i = 0; i < w; i++) begin
                sum[0] += hist[0][i];
                sum[1] += hist[1][i];
            end
            if (fill[0] >= w / 2 && fill[1] >= w / 2) begin
                avg_x = sum[0] / fill[0];
                avg_y = sum[1] / fill[1];
                total = avg_x + avg_y;
                if (total != 0) begin
                    pct_x = (avg_x * 100) / total;
                    pct_y = (avg_y * 100) / total;
                    if (!lock_x && !lock_y) begin
                        if (pct_x >= reg_threshold) begin
                            lock_x = 1'b1;
                        end else if (pct_y >= reg_threshold) begin
                            lock_y = 1'b1;
                        end
                    end else if (lock_x) begin
                        if (lock_released(pct_x)) begin
                            lock_x = 1'b0;
                        end
                    end else begin
                        if (lock_released(pct_y)) begin
                            lock_y = 1'b0;
                        end
                    end
                    hide = (lock_x && op == OP_Y) || (lock_y && op == OP_X);
                end
            end
        end
        r.kind  = op;
        r.value = hide ? '0 : raw;
        r.sync  = hide ? 1'b0 : sync;
        r.lock  = lock_x ? LOCK_X : (lock_y ? LOCK_Y : LOCK_NONE);
        predicted_beats.push_back(r);
    endtask

    always @(posedge aclk) begin
        clamp_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_beats.size() == 0) begin
                $display("%0t: unexpected beat kind %0d value %h sync %0d lock %0d", $time,
                         m_event_kind, m_value_out, m_sync_out, m_lock_state);
                fail_count++;
            end else begin
                want = predicted_beats.pop_front();
                if (m_event_kind !== want.kind) begin
                    $display("%0t: event_kind expected %0d actual %0d", $time, want.kind,
                             m_event_kind);
                    fail_count++;
                end
                if (m_value_out !== want.value) begin
                    $display("%0t: value_out expected %h actual %h", $time, want.value,
                             m_value_out);
                    fail_count++;
                end
                if (m_sync_out !== want.sync) begin
                    $display("%0t: sync_out expected %0d actual %0d", $time, want.sync,
                             m_sync_out);
                    fail_count++;
                end
                if (m_lock_state !== want.lock) begin
                    $display("%0t: lock_state expected %0d actual %0d", $time, want.lock,
                             m_lock_state);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                for (int held = 0; held < stall_len; held++) begin
                    @(posedge aclk);
                end
                stall_len = 0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_beat(input op_t op, input logic [VAL_W-1:0] val, input logic sync);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_motion_value <= val;
        s_sync_in      <= sync;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_clamp(op, val, sync);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (predicted_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input int data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= CFG_DW'(data);
        @(posedge aclk);
    endtask

    task automatic write_regs(input int win, input int thr, input int hys, input int tmo);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_HYSTERESIS, hys);
        write_reg(CFG_TIMEOUT, tmo);
        cfg_wr_en      <= 1'b0;
        reg_window     = WIN_W'(win);
        reg_threshold  = PCT_W'(thr);
        reg_hysteresis = PCT_W'(hys);
        reg_timeout    = TMO_W'(tmo);
        @(posedge aclk);
    endtask

    task automatic motion_burst(input int n, input int lim_x, input int lim_y,
                                input int pct_other, input int pct_tick);
        int               r;
        int               lim;
        int               mag;
        op_t              op;
        logic [VAL_W-1:0] val;
        logic             sync;
        for (int k = 0; k < n; k++) begin
            r    = $urandom_range(0, 99);
            sync = 1'($urandom_range(0, 1));
            if (r < pct_tick) begin
                send_beat(OP_TICK, VAL_W'($urandom), sync);
            end else if (r < pct_tick + pct_other) begin
                send_beat(OP_OTHER, VAL_W'($urandom), sync);
            end else begin
                op  = $urandom_range(0, 1) ? OP_Y : OP_X;
                lim = (op == OP_X) ? lim_x : lim_y;
                if (lim != 0 && $urandom_range(0, 15) == 0) begin
                    val = VAL_W'($urandom);
                end else begin
                    mag = $urandom_range(0, lim);
                    val = $urandom_range(0, 1) ? VAL_W'(-mag) : VAL_W'(mag);
                end
                send_beat(op, val, sync);
            end
        end
    endtask

    task automatic tick_run(input int n);
        for (int k = 0; k < n; k++) begin
            send_beat(OP_TICK, VAL_W'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    function automatic int pick_limit();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 50);
            1: return 1000;
            2: return $urandom_range(100, 8000);
            default: return 32767;
        endcase
    endfunction

    task automatic test_field_extremes();
        send_beat(OP_X, 16'h7FFF, 1'b1);
        send_beat(OP_X, 16'h8000, 1'b0);
        send_beat(OP_Y, 16'h0000, 1'b1);
        send_beat(OP_Y, 16'hFFFF, 1'b1);
        send_beat(OP_Y, 16'h0001, 1'b0);
        send_beat(OP_X, 16'h8001, 1'b1);
        send_beat(OP_OTHER, 16'h8000, 1'b1);
        send_beat(OP_OTHER, 16'h7FFF, 1'b0);
        send_beat(OP_OTHER, 16'h0000, 1'b1);
        send_beat(OP_TICK, 16'h5555, 1'b1);
        send_beat(OP_TICK, 16'hAAAA, 1'b0);
        send_beat(OP_X, 16'h7FFE, 1'b0);
        send_beat(OP_Y, 16'h4000, 1'b1);
        send_beat(OP_X, 16'hC000, 1'b1);
        send_beat(OP_Y, 16'h8000, 1'b0);
        send_beat(OP_OTHER, 16'hFFFF, 1'b0);
        settle();
    endtask

    task automatic test_axis_locking();
        write_regs(4, 60, 10, 1000);
        motion_burst(16, 30000, 100, 0, 0);
        motion_burst(16, 100, 30000, 0, 0);
        motion_burst(16, 8000, 8000, 10, 0);
        settle();
    endtask

    task automatic test_window_limits();
        int wins [5] = '{0, 1, 2, 32, 63};
        foreach (wins[i]) begin
            write_regs(wins[i], 45, 10, 500);
            motion_burst(30, 25000, 300, 5, 0);
            motion_burst(30, 300, 25000, 5, 0);
            settle();
        end
    endtask

    task automatic test_window_shrink();
        write_regs(32, 40, 5, 500);
        motion_burst(70, 20000, 500, 0, 0);
        settle();
        write_regs(5, 40, 5, 500);
        motion_burst(20, 500, 20000, 0, 0);
        settle();
        write_regs(20, 40, 5, 500);
        motion_burst(20, 10000, 10000, 0, 0);
        settle();
    endtask

    task automatic test_hysteresis_limits();
        write_regs(4, 20, 50, 500);
        motion_burst(20, 30000, 200, 0, 0);
        motion_burst(10, 200, 30000, 0, 0);
        settle();
        write_regs(4, 30, 30, 500);
        motion_burst(20, 30000, 2000, 0, 0);
        motion_burst(10, 0, 30000, 0, 0);
        settle();
    endtask

    task automatic test_threshold_limits();
        write_regs(4, 101, 0, 500);
        motion_burst(20, 30000, 0, 0, 0);
        settle();
        write_regs(4, 127, 127, 500);
        motion_burst(20, 0, 30000, 0, 0);
        settle();
        write_regs(6, 0, 0, 500);
        motion_burst(20, 5000, 5000, 0, 0);
        settle();
    endtask

    task automatic test_zero_motion();
        write_regs(2, 35, 5, 500);
        motion_burst(10, 0, 0, 0, 0);
        motion_burst(10, 30000, 0, 0, 0);
        settle();
        write_regs(2, 100, 0, 500);
        motion_burst(10, 0, 0, 0, 0);
        motion_burst(10, 5000, 0, 0, 0);
        motion_burst(10, 0, 5000, 0, 0);
        settle();
    endtask

    task automatic test_idle_timeout();
        write_regs(4, 55, 5, 10);
        motion_burst(12, 30000, 50, 0, 0);
        tick_run(9);
        motion_burst(4, 30000, 50, 0, 0);
        tick_run(10);
        motion_burst(6, 30000, 50, 0, 0);
        tick_run(5);
        send_beat(OP_OTHER, VAL_W'($urandom), 1'b1);
        tick_run(8);
        motion_burst(6, 50, 30000, 0, 0);
        settle();
        write_regs(4, 55, 5, 0);
        motion_burst(12, 30000, 50, 0, 0);
        tick_run(1);
        motion_burst(6, 30000, 50, 0, 30);
        settle();
        write_regs(4, 55, 5, 1);
        motion_burst(12, 50, 30000, 0, 0);
        tick_run(1);
        motion_burst(6, 50, 30000, 0, 0);
        settle();
        // full-scale timeout must not clear early
        write_regs(4, 55, 5, 65535);
        motion_burst(12, 30000, 50, 0, 0);
        quiet = 1'b1;
        tick_run(60);
        quiet = 1'b0;
        motion_burst(6, 30000, 50, 0, 0);
        settle();
    endtask

    task automatic test_output_stall();
        write_regs(6, 50, 10, 300);
        stall_len = 400;
        motion_burst(14, 20000, 20000, 20, 0);
        settle();
    endtask

    task automatic test_random_traffic();
        int win;
        int thr;
        int hys;
        int tmo;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            win = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 12);
            thr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(20, 80);
            hys = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 25);
            case ($urandom_range(0, 5))
                0: tmo = 0;
                1: tmo = 65535;
                default: tmo = $urandom_range(5, 80);
            endcase
            write_regs(win, thr, hys, tmo);
            quiet = (ph == RANDOM_PHASES - 1);
            for (int seg = 0; seg < 6; seg++) begin
                motion_burst(20, pick_limit(), pick_limit(), 5, $urandom_range(0, 15));
            end
            settle();
        end
    endtask

    initial begin
        s_valid        <= 1'b0;
        s_opcode       <= OP_OTHER;
        s_motion_value <= '0;
        s_sync_in      <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_addr       <= CFG_WINDOW;
        cfg_wr_data    <= '0;
        aresetn        <= 1'b0;
        fail_count     = 0;
        cycle_count    = 0;
        quiet          = 1'b0;
        stall_len      = 0;
        wipe_mirror();
        idle_ticks     = 0;
        reg_window     = WINDOW_RST;
        reg_threshold  = THRESHOLD_RST;
        reg_hysteresis = HYSTERESIS_RST;
        reg_timeout    = TIMEOUT_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_axis_locking();
        test_window_limits();
        test_window_shrink();
        test_hysteresis_limits();
        test_threshold_limits();
        test_zero_motion();
        test_idle_timeout();
        test_output_stall();
        test_random_traffic();
        settle();

        if (fail_count == 0) begin
            $display("dominant_axis_motion_clamper test passed");
        end else begin
            $display("dominant_axis_motion_clamper test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
